[src/btcd_pkg.sv]
`timescale 1ns / 1ps
package btcd_pkg;
    typedef struct packed {
        logic        inhaling;
        logic [31:0] trigger_setting;
        logic [31:0] cycle_setting;
        logic [31:0] flow_raw;
        logic [31:0] flow_comp;
        logic [31:0] pressure_error;
        logic [30:0] exhale_time;
        logic [30:0] recent_exhale_time;
        logic [31:0] inhale_peak_flow;
        logic [15:0] pre_cycle_ticks;
        logic        pre_trigger_active;
        logic        ipap_constant;
    } t_in;

    typedef struct packed {
        logic [31:0] trigger_out;
        logic [31:0] cycle_out;
    } t_out;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } t_cfg;

    localparam logic [1:0] REG_TRIG_EN   = 2'd0;
    localparam logic [1:0] REG_CYCLE_EN  = 2'd1;
    localparam logic [1:0] REG_PRE_LIMIT = 2'd2;

    // divider handshake
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage

[src/btcd_if.sv]
`timescale 1ns / 1ps
interface btcd_in_if;
    logic valid;
    logic ready;
    btcd_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface btcd_out_if;
    logic valid;
    logic ready;
    btcd_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface btcd_cfg_if;
    logic valid;
    logic ready;
    btcd_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/breath_trigger_cycle_decider.sv]
`timescale 1ns / 1ps
// Inhale results skip the custom score; in exhale it runs up to six remap terms, each
// waiting on the shared 64-step divider (a zero trigger span skips its division).
// One item at a time; the next transaction is accepted in the cycle after
// the result is taken.
// Reset (synchronous, active low) clears control and setting state; sets limit to 100.
module breath_trigger_cycle_decider #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    btcd_in_if.sink    in_ch,
    btcd_out_if.source out_ch,
    btcd_cfg_if.sink   cfg_ch
);
    import btcd_pkg::*;

    localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;
    localparam longint ONEL = longint'(1) << FRAC_BITS;
    localparam logic signed [65:0] C_0225 = 66'((225 * ONEL + 500) / 1000);
    localparam logic signed [65:0] C_095  = 66'((95 * ONEL + 50) / 100);
    localparam logic signed [65:0] C_6000 = 66'((ONEL + 3000) / 6000);
    localparam logic signed [65:0] C_12   = 66'((12 * ONEL + 5) / 10);
    localparam logic signed [65:0] C_002  = 66'((2 * ONEL + 50) / 100);
    localparam logic signed [65:0] C_004  = 66'((4 * ONEL + 50) / 100);
    localparam logic signed [65:0] C_0015 = 66'((15 * ONEL + 500) / 1000);
    localparam logic signed [65:0] C_005  = 66'((5 * ONEL + 50) / 100);
    localparam logic signed [65:0] C_03   = 66'((3 * ONEL + 5) / 10);
    localparam logic signed [65:0] C_02   = 66'((2 * ONEL + 5) / 10);
    localparam logic signed [65:0] C_01   = 66'((ONEL + 5) / 10);
    localparam logic signed [65:0] C_035  = 66'((35 * ONEL + 50) / 100);
    localparam logic signed [65:0] T_FORCE  = -(66'sd5 <<< FRAC_BITS);
    localparam logic signed [65:0] T_FORBID = 66'sd999 <<< FRAC_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PRE   = 9'b000000010,
        S_MULW  = 9'b000000100,
        S_VOL   = 9'b000001000,
        S_RSET  = 9'b000010000,
        S_RDIV  = 9'b000100000,
        S_RMUL  = 9'b001000000,
        S_RACC  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    t_in    r_in;
    logic   r_trig_en, r_cyc_en;
    logic [15:0] r_limit;
    logic signed [31:0] r_last_t, r_user_t, r_last_c, r_user_c, r_vol;
    logic signed [65:0] r_trig, r_cyc, r_score, r_t1;
    logic [2:0] r_idx;
    logic       r_ovalid;
    t_out       r_out;

    // shared multiplier and divider
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic        w_dstart;
    logic [63:0] w_dnum, w_dden, w_dquo;
    logic        w_dbusy;

    btcd_mul #(.FB(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    btcd_div #(.W(64)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_busy(w_dbusy), .o_quo(w_dquo));

    function automatic logic signed [31:0] sat(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // remap operands for step r_idx: 0 flow, 1/2 volume, 3/4 perr, 5 dt
    logic signed [65:0] w_x, w_lo, w_hi, w_span, w_num, w_dt;
    always_comb begin
        w_dt = $signed({35'd0, r_in.recent_exhale_time})
             - $signed({35'd0, r_in.exhale_time});
        if (w_dt < 0) w_dt = -w_dt;
        case (r_idx)
            3'd0: begin
                w_x = 66'($signed(r_in.flow_comp)); w_lo = '0; w_hi = 66'(r_user_t);
            end
            3'd1: begin w_x = 66'(r_vol); w_lo = C_002; w_hi = C_004; end
            3'd2: begin w_x = 66'(r_vol); w_lo = C_0015; w_hi = C_005; end
            3'd3: begin
                w_x = 66'($signed(r_in.pressure_error)); w_lo = -C_01; w_hi = -C_035;
            end
            3'd4: begin
                w_x = 66'($signed(r_in.pressure_error)); w_lo = C_01; w_hi = C_035;
            end
            default: begin w_x = w_dt; w_lo = C_03; w_hi = '0; end
        endcase
        w_span = w_hi - w_lo;
        w_num  = (w_x - w_lo) <<< FRAC_BITS;
    end

    // sign-aware quotient magnitude; clamp to [0, ONE]
    logic        r_neg;
    logic signed [65:0] w_t;
    always_comb begin
        if (r_neg) w_t = '0;
        else if ($signed({2'b0, w_dquo}) > ONE) w_t = ONE;
        else w_t = $signed({2'b0, w_dquo});
    end
    assign w_dnum = w_num[65] ? 64'(-w_num) : w_num[63:0];
    assign w_dden = w_span[65] ? 64'(-w_span) : w_span[63:0];
    assign w_dstart = (r_state == S_RSET) && (w_span != 0);

    // skip terms that do not apply
    logic w_cte_ok;
    logic [2:0] w_next_idx;
    assign w_cte_ok = $signed({35'd0, r_in.exhale_time}) >= C_12;
    always_comb begin
        case (r_idx)
            3'd0:    w_next_idx = w_cte_ok ? 3'd1 : (r_in.ipap_constant ? 3'd3 : 3'd5);
            3'd1:    w_next_idx = 3'd2;
            3'd2:    w_next_idx = r_in.ipap_constant ? 3'd3 : 3'd5;
            3'd3:    w_next_idx = 3'd4;
            default: w_next_idx = 3'd5;
        endcase
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PRE: begin
                w_ma = 33'($signed(r_in.inhale_peak_flow));
                w_mb = 33'(-C_0225 + (66'(r_user_c) >>> 1));
            end
            S_MULW: begin
                w_ma = 33'($signed(r_in.flow_comp));
                w_mb = 33'(C_6000);
            end
            S_RMUL: begin
                w_ma = 33'(r_t1);
                case (r_idx)
                    3'd1: w_mb = 33'(C_03);
                    3'd2: w_mb = 33'(C_02);
                    3'd4: w_mb = 33'(C_03);
                    default: w_mb = 33'(C_02);
                endcase
            end
            default: ;
        endcase
    end

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_trig_en <= 1'b0;
            r_cyc_en  <= 1'b0;
            r_limit   <= 16'd100;
            r_last_t  <= '0;
            r_user_t  <= '0;
            r_last_c  <= '0;
            r_user_c  <= '0;
            r_vol     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                case (cfg_ch.data.index)
                    REG_TRIG_EN:   r_trig_en <= cfg_ch.data.data[0];
                    REG_CYCLE_EN:  r_cyc_en  <= cfg_ch.data.data[0];
                    REG_PRE_LIMIT: r_limit   <= cfg_ch.data.data[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in <= in_ch.data;
                        if ($signed(in_ch.data.trigger_setting) != r_last_t)
                            r_user_t <= in_ch.data.trigger_setting;
                        if ($signed(in_ch.data.cycle_setting) != r_last_c)
                            r_user_c <= in_ch.data.cycle_setting;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_trig <= r_trig_en ? 66'($signed(r_in.trigger_setting)) : 66'(r_user_t);
                    r_cyc  <= r_cyc_en ? 66'($signed(r_in.cycle_setting)) : 66'(r_user_c);
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (r_in.inhaling) begin
                        if (r_cyc_en) begin
                            if (66'($signed(r_in.flow_raw)) < w_mp
                                || r_in.pre_cycle_ticks >= r_limit)
                                r_cyc <= C_095;
                            else
                                r_cyc <= -(ONE >>> 1);
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_VOL;
                    end
                end
                S_VOL: begin
                    r_trig  <= 66'(r_user_t);
                    if ($signed(r_in.flow_comp) < 0) r_vol <= '0;
                    else r_vol <= sat(66'(r_vol) + w_mp);
                    r_idx   <= 3'd0;
                    r_score <= '0;
                    if (r_trig_en && (r_in.ipap_constant || r_in.pre_trigger_active))
                        r_state <= S_RSET;
                    else
                        r_state <= S_OUT;
                end
                S_RSET: begin
                    r_neg   <= (w_span == 0)
                            || ((w_num[65] != w_span[65]) && (w_num != 0));
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    if (!w_dbusy) begin
                        case (r_idx)
                            3'd0: begin
                                r_score <= w_t;
                                r_state <= S_RACC;
                            end
                            3'd3: begin
                                r_t1    <= w_t;
                                r_state <= S_RACC;
                            end
                            3'd4: begin
                                r_t1    <= r_t1 - w_t;
                                r_state <= S_RMUL;
                            end
                            default: begin
                                r_t1    <= w_t;
                                r_state <= S_RMUL;
                            end
                        endcase
                    end
                end
                S_RMUL: r_state <= S_RACC;
                S_RACC: begin
                    if (r_idx == 3'd1 || r_idx == 3'd5 || r_idx == 3'd4)
                        r_score <= r_score + w_mp;
                    else if (r_idx == 3'd2)
                        r_score <= r_score - w_mp;
                    if (r_idx == 3'd5) begin
                        r_state <= S_OUT;
                        r_trig  <= ((r_score + w_mp) >= ONE) ? T_FORCE : T_FORBID;
                    end else begin
                        r_idx   <= w_next_idx;
                        r_state <= S_RSET;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out.trigger_out <= sat(r_trig);
                        r_out.cycle_out   <= sat(r_cyc);
                        r_last_t <= sat(r_trig);
                        r_last_c <= sat(r_cyc);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/btcd_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; unsigned magnitudes.
module btcd_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic [W:0]    w_tr;

    assign w_tr = {r_rem, r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (w_tr >= {1'b0, r_den}) begin
                r_rem <= W'(w_tr - {1'b0, r_den});
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= w_tr[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
endmodule

[src/btcd_mul.sv]
`timescale 1ns / 1ps
// Registered signed 33x33 multiply followed by floor shift.
module btcd_mul #(
    parameter int FB = 16
) (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p >>> FB;
endmodule

[src/btcd_checker.sv]
`timescale 1ns / 1ps
module btcd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] out_data
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input ready with pending result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind breath_trigger_cycle_decider btcd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data));
